// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Every property is sampled on the rising edge of clk and ignored while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aiol_pkg.sv =====
`default_nettype none

package aiol_pkg;

    // Operation classes
    localparam logic [1:0] MODE_MOVE    = 2'd0;
    localparam logic [1:0] MODE_ADDSUB  = 2'd1;
    localparam logic [1:0] MODE_COMPARE = 2'd2;

    // How the constant is carried
    typedef enum logic [1:0] {
        KIND_ONE_IMM  = 2'd0,
        KIND_TWO_IMM  = 2'd1,
        KIND_LIT_DEST = 2'd2,
        KIND_LIT_TEMP = 2'd3
    } kind_t;

    // Beat as taken from the input port
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic        sets_flags;
        logic        is_unconditional;
    } aiol_in_t;

    // After the operand preparation stage
    typedef struct packed {
        logic [1:0]  mode;
        logic        sets_flags;
        logic        is_unconditional;
        logic [31:0] value;
        logic [31:0] alt_value;
    } aiol_prep_t;

    // After the mask matching stage
    typedef struct packed {
        logic [1:0]  mode;
        logic        sets_flags;
        logic        is_unconditional;
        logic [31:0] value;
        logic [31:0] alt_value;
        logic [15:0] fit_v;
        logic [15:0] fit_a;
        logic [15:0] split_v;
        logic [15:0] split_a;
    } aiol_match_t;

    // After the selection stage
    typedef struct packed {
        kind_t       kind;
        logic        use_alternate;
        logic [3:0]  rot_first;
        logic [31:0] part;
        logic [31:0] rest;
    } aiol_sel_t;

    // Result beat
    typedef struct packed {
        kind_t       result_kind;
        logic        use_alternate;
        logic [11:0] first_encoding;
        logic [11:0] second_encoding;
    } aiol_out_t;

    // Rotation masks: an 8-bit field rotated right by twice the index
    function automatic logic [31:0] rot_mask(input logic [3:0] k);
        logic [63:0] dbl;
        dbl = {32'h0000_00ff, 32'h0000_00ff} >> {k, 1'b0};
        return dbl[31:0];
    endfunction

    // Lowest set bit index of a 16-bit vector, zero when empty
    function automatic logic [3:0] first_set(input logic [15:0] bits);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (bits[i])
                idx = 4'(i);
        end
        return idx;
    endfunction

    // Encode rotate index and byte: value rotated left by 2k gives the byte
    function automatic logic [11:0] pack_imm(input logic [31:0] v, input logic [3:0] k);
        logic [63:0] dbl;
        dbl = {v, v} << {k, 1'b0};
        return {k, dbl[39:32]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aiol_prep_stage.sv =====
`default_nettype none

module aiol_prep_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  aiol_pkg::aiol_in_t     in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output aiol_pkg::aiol_prep_t   out_data
);
    import aiol_pkg::*;

    logic       valid_reg;
    aiol_prep_t data_reg;
    aiol_prep_t data_next;

    // Stage takes a beat when empty or when the next stage drains it
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Alternate operand: complement for a move, negation otherwise
    always_comb
    begin
        data_next.mode             = in_data.mode;
        data_next.sets_flags       = in_data.sets_flags;
        data_next.is_unconditional = in_data.is_unconditional;
        data_next.value            = in_data.value;
        if (in_data.mode == MODE_MOVE)
            data_next.alt_value = ~in_data.value;
        else
            data_next.alt_value = 32'd0 - in_data.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/aiol_match_stage.sv =====
`default_nettype none

module aiol_match_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  aiol_pkg::aiol_prep_t   in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output aiol_pkg::aiol_match_t  out_data
);
    import aiol_pkg::*;

    logic        valid_reg;
    aiol_match_t data_reg;
    aiol_match_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Single-immediate fit per rotation, and split fit per mask pair.
    // Zero matches every mask, so a zero leftover always counts as a fit.
    always_comb
    begin
        data_next.mode             = in_data.mode;
        data_next.sets_flags       = in_data.sets_flags;
        data_next.is_unconditional = in_data.is_unconditional;
        data_next.value            = in_data.value;
        data_next.alt_value        = in_data.alt_value;
        for (int i = 0; i < 16; i++)
        begin
            data_next.fit_v[i]   = (in_data.value & ~rot_mask(4'(i))) == 32'd0;
            data_next.fit_a[i]   = (in_data.alt_value & ~rot_mask(4'(i))) == 32'd0;
            data_next.split_v[i] = 1'b0;
            data_next.split_a[i] = 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                if ((in_data.value & ~rot_mask(4'(i)) & ~rot_mask(4'(k))) == 32'd0)
                    data_next.split_v[i] = 1'b1;
                if ((in_data.alt_value & ~rot_mask(4'(i)) & ~rot_mask(4'(k))) == 32'd0)
                    data_next.split_a[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/aiol_select_stage.sv =====
`default_nettype none

module aiol_select_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  aiol_pkg::aiol_match_t  in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output aiol_pkg::aiol_sel_t    out_data
);
    import aiol_pkg::*;

    logic       valid_reg;
    aiol_sel_t  data_reg;
    aiol_sel_t  data_next;
    logic       negative;
    logic [3:0] k_v;
    logic [3:0] k_a;
    logic [3:0] i_v;
    logic [3:0] i_a;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign negative = in_data.value[31];
    assign k_v      = first_set(in_data.fit_v);
    assign k_a      = first_set(in_data.fit_a);
    assign i_v      = first_set(in_data.split_v);
    assign i_a      = first_set(in_data.split_a);

    // Choose how the constant is carried; rest stays zero unless split
    always_comb
    begin
        data_next.kind          = KIND_LIT_DEST;
        data_next.use_alternate = 1'b0;
        data_next.rot_first     = 4'd0;
        data_next.part          = 32'd0;
        data_next.rest          = 32'd0;
        unique case (in_data.mode)
            MODE_MOVE, MODE_COMPARE:
            begin
                if (|in_data.fit_v)
                begin
                    data_next.kind      = KIND_ONE_IMM;
                    data_next.rot_first = k_v;
                    data_next.part      = in_data.value;
                end
                else if (|in_data.fit_a)
                begin
                    data_next.kind          = KIND_ONE_IMM;
                    data_next.use_alternate = 1'b1;
                    data_next.rot_first     = k_a;
                    data_next.part          = in_data.alt_value;
                end
                else if (in_data.mode == MODE_COMPARE)
                    data_next.kind = KIND_LIT_TEMP;
                else
                    data_next.kind = KIND_LIT_DEST;
            end
            MODE_ADDSUB:
            begin
                priority if (|in_data.fit_v)
                begin
                    data_next.kind      = KIND_ONE_IMM;
                    data_next.rot_first = k_v;
                    data_next.part      = in_data.value;
                end
                else if (negative && (|in_data.fit_a))
                begin
                    data_next.kind          = KIND_ONE_IMM;
                    data_next.use_alternate = 1'b1;
                    data_next.rot_first     = k_a;
                    data_next.part          = in_data.alt_value;
                end
                else if (in_data.sets_flags && !in_data.is_unconditional)
                    data_next.kind = KIND_LIT_TEMP;
                else if (|in_data.split_v)
                begin
                    data_next.kind      = KIND_TWO_IMM;
                    data_next.rot_first = i_v;
                    data_next.part      = in_data.value & rot_mask(i_v);
                    data_next.rest      = in_data.value & ~rot_mask(i_v);
                end
                else if (negative && (|in_data.split_a))
                begin
                    data_next.kind          = KIND_TWO_IMM;
                    data_next.use_alternate = 1'b1;
                    data_next.rot_first     = i_a;
                    data_next.part          = in_data.alt_value & rot_mask(i_a);
                    data_next.rest          = in_data.alt_value & ~rot_mask(i_a);
                end
                else
                    data_next.kind = KIND_LIT_TEMP;
            end
            default:
                data_next.kind = KIND_LIT_DEST;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/aiol_pack_stage.sv =====
`default_nettype none

module aiol_pack_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  aiol_pkg::aiol_sel_t    in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output aiol_pkg::aiol_out_t    out_data
);
    import aiol_pkg::*;

    logic        valid_reg;
    aiol_out_t   data_reg;
    aiol_out_t   data_next;
    logic [15:0] rest_fit;
    logic [3:0]  k_rest;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Rotation for the leftover part; zero leftover encodes as zero
    always_comb
    begin
        for (int k = 0; k < 16; k++)
            rest_fit[k] = (in_data.rest & ~rot_mask(4'(k))) == 32'd0;
    end

    assign k_rest = first_set(rest_fit);

    // Pack both immediates; unused parts were cleared upstream
    always_comb
    begin
        data_next.result_kind     = in_data.kind;
        data_next.use_alternate   = in_data.use_alternate;
        data_next.first_encoding  = pack_imm(in_data.part, in_data.rot_first);
        data_next.second_encoding = pack_imm(in_data.rest, k_rest);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/arm_immediate_operand_legalizer_unit.sv =====
// ARM immediate operand legaliser.
// Input stream (s_axis_*): one beat per constant, the operation class in tuser and
// the constant with its flag bits in tdata. Output stream (m_axis_*): one beat per
// input beat, in order: the way of carrying the constant in tuser, the alternate
// opcode flag and both 12-bit rotated immediates in tdata.
// Four register stages: operand preparation (complement or negation), mask
// matching (16 single and 16x16 split checks), selection, and packing into the
// output register. Throughput is one beat per cycle while the output is not
// stalled; every stage holds its own valid bit.
// When the receiver stalls, the output register holds its beat and the stages
// behind it keep filling until the pipeline is full, so up to four beats are
// held; no beat is dropped or repeated. s_axis_tready is low only when all
// stages are occupied and the output is stalled.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module arm_immediate_operand_legalizer_unit (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [39:0]  s_axis_tdata,  // value[31:0], sets_flags, is_unconditional, zero pad
    input  wire  [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // use_alternate, first_encoding, second_encoding, pad
    output logic [1:0]   m_axis_tuser   // result_kind
);
    import aiol_pkg::*;

    aiol_in_t    in_beat;
    aiol_prep_t  prep_data;
    aiol_match_t match_data;
    aiol_sel_t   sel_data;
    aiol_out_t   out_beat;
    logic        prep_valid;
    logic        prep_ready;
    logic        match_valid;
    logic        match_ready;
    logic        sel_valid;
    logic        sel_ready;

    // Unpack input beat
    assign in_beat.mode             = s_axis_tuser;
    assign in_beat.value            = s_axis_tdata[31:0];
    assign in_beat.sets_flags       = s_axis_tdata[32];
    assign in_beat.is_unconditional = s_axis_tdata[33];

    aiol_prep_stage u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_beat),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    aiol_match_stage u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (match_valid),
        .out_ready (match_ready),
        .out_data  (match_data)
    );

    aiol_select_stage u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (match_valid),
        .in_ready  (match_ready),
        .in_data   (match_data),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_data  (sel_data)
    );

    aiol_pack_stage u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_beat)
    );

    // Pack output beat
    assign m_axis_tuser = out_beat.result_kind;
    assign m_axis_tdata = {7'd0, out_beat.second_encoding, out_beat.first_encoding,
                           out_beat.use_alternate};

endmodule

`default_nettype wire

// ===== rtl/aiol_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module aiol_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [39:0]  s_axis_tdata,
    input wire [1:0]   s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [31:0]  m_axis_tdata,
    input wire [1:0]   m_axis_tuser
);
    import aiol_pkg::*;

    logic        lit_kind;
    logic        stalled;
    logic [33:0] out_bits;
    logic        lit_clear;
    logic        second_clear;

    assign lit_kind = (m_axis_tuser == KIND_LIT_DEST) || (m_axis_tuser == KIND_LIT_TEMP);
    assign stalled  = m_axis_tvalid && !m_axis_tready;
    assign out_bits = {m_axis_tuser, m_axis_tdata};

    // Literal loads carry no immediates and no alternate opcode
    assign lit_clear = !(m_axis_tvalid && lit_kind) || (m_axis_tdata == 32'd0);

    // Only a split fills the second immediate
    assign second_clear = !(m_axis_tvalid && (m_axis_tuser != KIND_TWO_IMM))
                          || (m_axis_tdata[24:13] == 12'd0);

    // A stalled result beat stays and does not change
    `ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid, "output beat withdrawn while stalled")
    `ASSERT_NEXT(a_out_stable, stalled, $stable(out_bits), "output beat changed while stalled")

    `ASSERT_CLK(a_lit_empty, lit_clear, "literal result with non-zero fields")
    `ASSERT_CLK(a_second_split, second_clear, "second immediate outside a split")

    // Input side is ready whenever the output side drains
    `ASSERT_CLK(a_in_ready, !m_axis_tready || s_axis_tready, "input stalled while output drains")

endmodule

bind arm_immediate_operand_legalizer_unit aiol_checker u_aiol_checker (.*);

`default_nettype wire

// ===== test/arm_immediate_operand_legalizer_unit_tb.sv =====
`timescale 1ns / 100ps

module arm_immediate_operand_legalizer_unit_tb;

    import aiol_pkg::*;

    // Operation class that the block does not define
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 60;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // value[31:0], sets_flags, is_unconditional, zero pad
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // use_alternate, first_encoding, second_encoding, pad
    logic [1:0]  m_axis_tuser;        // result_kind

    aiol_out_t expected_results[$];
    aiol_out_t want_beat;
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        send_idle = 1'b1;      // owned by the stimulus process
    logic      recv_idle = 1'b1;      // written with NBA, read by the receiver
    int        hold_request_id = 0;   // bumped with NBA to ask for a long output stall

    arm_immediate_operand_legalizer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Rotate right, amount taken modulo 32
    function automatic logic [31:0] ror32(input logic [31:0] v, input int amount);
        int r;
        r = amount & 31;
        if (r == 0)
            return v;
        return (v >> r) | (v << (32 - r));
    endfunction

    // Byte field rotated right by twice the index
    function automatic logic [31:0] byte_window(input int k);
        return ror32(32'h0000_00ff, 2 * k);
    endfunction

    // Rotate index over the byte recovered by rotating back left
    function automatic logic [11:0] imm_field(input logic [31:0] v, input int k);
        logic [31:0] back;
        back = ror32(v, 32 - 2 * k);
        return {4'(k), back[7:0]};
    endfunction

    function automatic bit fits_rotated(input logic [31:0] v, output logic [11:0] enc);
        enc = 12'd0;
        if (v == 32'd0)
            return 1'b1;
        for (int k = 0; k < 16; k++)
        begin
            if ((v & ~byte_window(k)) == 32'd0)
            begin
                enc = imm_field(v, k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // First window whose leftover still fits as a single immediate
    function automatic bit two_part(input logic [31:0] v, output logic [11:0] e1,
                                    output logic [11:0] e2);
        logic [31:0] rest;
        e1 = 12'd0;
        e2 = 12'd0;
        for (int k = 0; k < 16; k++)
        begin
            rest = v & ~byte_window(k);
            if (fits_rotated(rest, e2))
            begin
                e1 = imm_field(v & byte_window(k), k);
                return 1'b1;
            end
        end
        e2 = 12'd0;
        return 1'b0;
    endfunction

    // Expected output beat for one constant
    function automatic aiol_out_t legalise_constant(input logic [1:0] mode,
                                                    input logic [31:0] value,
                                                    input logic sf, input logic unc);
        aiol_out_t   res;
        logic [31:0] neg;
        logic [11:0] e1;
        logic [11:0] e2;
        bit          negative;
        neg = 32'd0 - value;
        negative = value[31];
        e1 = 12'd0;
        e2 = 12'd0;
        res.result_kind = KIND_LIT_DEST;
        res.use_alternate = 1'b0;
        res.first_encoding = 12'd0;
        res.second_encoding = 12'd0;
        case (mode)
            MODE_MOVE:
            begin
                if (fits_rotated(value, e1))
                    res.result_kind = KIND_ONE_IMM;
                else if (fits_rotated(~value, e1))
                begin
                    res.result_kind = KIND_ONE_IMM;
                    res.use_alternate = 1'b1;
                end
                else
                    res.result_kind = KIND_LIT_DEST;
            end
            MODE_COMPARE:
            begin
                if (fits_rotated(value, e1))
                    res.result_kind = KIND_ONE_IMM;
                else if (fits_rotated(neg, e1))
                begin
                    res.result_kind = KIND_ONE_IMM;
                    res.use_alternate = 1'b1;
                end
                else
                    res.result_kind = KIND_LIT_TEMP;
            end
            MODE_ADDSUB:
            begin
                if (fits_rotated(value, e1))
                    res.result_kind = KIND_ONE_IMM;
                else if (negative && fits_rotated(neg, e1))
                begin
                    res.result_kind = KIND_ONE_IMM;
                    res.use_alternate = 1'b1;
                end
                else if (sf && !unc)
                    res.result_kind = KIND_LIT_TEMP;
                else if (two_part(value, e1, e2))
                    res.result_kind = KIND_TWO_IMM;
                else if (negative && two_part(neg, e1, e2))
                begin
                    res.result_kind = KIND_TWO_IMM;
                    res.use_alternate = 1'b1;
                end
                else
                    res.result_kind = KIND_LIT_TEMP;
            end
            default:
                res.result_kind = KIND_LIT_DEST;
        endcase
        if (res.result_kind == KIND_ONE_IMM || res.result_kind == KIND_TWO_IMM)
            res.first_encoding = e1;
        if (res.result_kind == KIND_TWO_IMM)
            res.second_encoding = e2;
        return res;
    endfunction

    // Constants biased towards the interesting encodings
    function automatic logic [31:0] random_constant();
        logic [31:0] a;
        logic [31:0] b;
        a = ror32({24'd0, 8'($urandom)}, 2 * $urandom_range(0, 15));
        b = ror32({24'd0, 8'($urandom)}, 2 * $urandom_range(0, 15));
        case ($urandom_range(0, 6))
            0: return a;
            1: return ~a;
            2: return 32'd0 - a;
            3: return a | b;
            4: return 32'd0 - (a | b);
            5: return $urandom;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7fff_ffff;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // Offer one beat, with an optional idle burst first; returns on acceptance
    task automatic send_beat(input logic [1:0] mode, input logic [31:0] value,
                             input logic sf, input logic unc);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {6'd0, unc, sf, value};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Extremes, every class and each special case
    task automatic test_directed();
        send_beat(MODE_MOVE, 32'h0000_0000, 1'b0, 1'b1);
        send_beat(MODE_MOVE, 32'h0000_00ff, 1'b1, 1'b0);
        send_beat(MODE_MOVE, 32'hf000_000f, 1'b0, 1'b0);   // wraps across bit 31
        send_beat(MODE_MOVE, 32'h0000_03fc, 1'b1, 1'b1);   // last rotation
        send_beat(MODE_MOVE, 32'hffff_ff00, 1'b0, 1'b1);   // MVN
        send_beat(MODE_MOVE, 32'hffff_ffff, 1'b1, 1'b1);   // MVN of zero
        send_beat(MODE_MOVE, 32'h1234_5678, 1'b0, 1'b1);   // literal pool
        send_beat(MODE_MOVE, 32'h8000_0000, 1'b1, 1'b0);
        send_beat(MODE_COMPARE, 32'hffff_ffff, 1'b1, 1'b1); // CMN 1
        send_beat(MODE_COMPARE, 32'h8000_0000, 1'b0, 1'b0); // negates to itself
        send_beat(MODE_COMPARE, 32'h1234_5678, 1'b1, 1'b0);
        send_beat(MODE_COMPARE, 32'hffff_ff01, 1'b0, 1'b1);
        send_beat(MODE_ADDSUB, 32'h0000_0104, 1'b0, 1'b1);
        send_beat(MODE_ADDSUB, 32'hffff_ff00, 1'b1, 1'b0);  // opposite opcode
        send_beat(MODE_ADDSUB, 32'h0000_0101, 1'b0, 1'b0);  // split
        send_beat(MODE_ADDSUB, 32'h0000_0101, 1'b1, 1'b0);  // conditional flags: no split
        send_beat(MODE_ADDSUB, 32'h0000_0101, 1'b1, 1'b1);
        send_beat(MODE_ADDSUB, 32'hffff_feff, 1'b0, 1'b1);  // split of the negation
        send_beat(MODE_ADDSUB, 32'h1234_5678, 1'b0, 1'b1);  // no split at all
        send_beat(MODE_ADDSUB, 32'h8000_0000, 1'b1, 1'b0);
        send_beat(MODE_ADDSUB, 32'h7fff_ffff, 1'b0, 1'b0);
        send_beat(MODE_ADDSUB, 32'h8000_0001, 1'b1, 1'b1);
        send_beat(MODE_ADDSUB, 32'h00ff_00ff, 1'b0, 1'b1);
        send_beat(MODE_UNUSED, 32'h1234_5678, 1'b1, 1'b1);
        send_beat(MODE_UNUSED, 32'h0000_0000, 1'b0, 1'b0);
    endtask

    task automatic test_random_constants(input int count);
        logic [1:0] mode;
        for (int n = 0; n < count; n++)
        begin
            mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            send_beat(mode, random_constant(), 1'($urandom), 1'($urandom));
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input
    task automatic test_output_stall();
        hold_request_id <= hold_request_id + 1;
        test_random_constants(20);
    endtask

    // Sender stops until every outstanding beat has come out
    task automatic test_pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Final stretch at full rate on both sides
    task automatic test_back_to_back();
        send_idle = 1'b0;
        recv_idle <= 1'b0;
        test_random_constants(40);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Receiver: short random stalls, plus one long hold on request
    initial
    begin : receiver
        int stall_left;
        int long_left;
        int hold_seen_id;
        stall_left = 0;
        long_left = 0;
        hold_seen_id = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request_id != hold_seen_id)
            begin
                hold_seen_id = hold_request_id;
                long_left = LONG_HOLD;
            end
            if (long_left > 0)
            begin
                long_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Predict each accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(legalise_constant(s_axis_tuser, s_axis_tdata[31:0],
                                                         s_axis_tdata[32],
                                                         s_axis_tdata[33]));
    end

    // Compare each accepted output beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: output beat with nothing expected: kind %h, data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_beat = expected_results.pop_front();
                check_field("result_kind", 32'(want_beat.result_kind), 32'(m_axis_tuser));
                check_field("use_alternate", 32'(want_beat.use_alternate),
                            32'(m_axis_tdata[0]));
                check_field("first_encoding", 32'(want_beat.first_encoding),
                            32'(m_axis_tdata[12:1]));
                check_field("second_encoding", 32'(want_beat.second_encoding),
                            32'(m_axis_tdata[24:13]));
                check_field("tdata pad", 32'd0, 32'(m_axis_tdata[31:25]));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_constants(300);
        test_output_stall();
        test_pause_until_drained();
        test_random_constants(280);
        test_back_to_back();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
